// ----- src/vpsa_pkg.sv -----
package vpsa_pkg;

   // fixed geometry, tied to the field widths below
   localparam int NUM_PAGES       = 512;
   localparam int BLOCKS_PER_PAGE = 32;

   typedef enum logic [1:0] {
      OP_ALLOC_PAGES = 2'd0,
      OP_ALLOC_SLOT  = 2'd1,
      OP_FREE        = 2'd2,
      OP_QUERY       = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_BAD_COUNT    = 3'd1,
      ST_NO_SPACE     = 3'd2,
      ST_TABLE_FULL   = 3'd3,
      ST_PALETTE_FULL = 3'd4,
      ST_UNKNOWN_RES  = 3'd5,
      ST_UNKNOWN_SLOT = 3'd6
   } status_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [8:0] req_page;
      logic [9:0] req_count;
      logic [4:0] req_block;
   } req_type;

   typedef struct packed {
      logic       ok;
      logic [2:0] status;
      logic [8:0] out_page;
      logic [9:0] out_count;
      logic [4:0] out_block;
      logic [9:0] pages_free;
      logic [9:0] largest_run;
   } rsp_type;

endpackage

// ----- src/vpsa_req_if.sv -----
interface vpsa_req_if;
   logic               valid;
   logic               ready;
   vpsa_pkg::req_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- src/vpsa_rsp_if.sv -----
interface vpsa_rsp_if;
   logic               valid;
   logic               ready;
   vpsa_pkg::rsp_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- src/vpsa_ram.sv -----
// Single-port-write, single-read RAM with registered read data
module vpsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- src/vram_page_and_slot_allocator_core.sv -----
// Page and palette-slot allocator.
// A full-size page grant is the longest case, from accept to result valid; a run free walks
// the reservation table and then the page map, and a query walks the page map.
// Throughput: one request at a time; the next is taken once the result has been accepted.
// Reset: synchronous; a clearing pass over the page map runs first, during
// which no request is taken. Reservation valid bits are flip-flops cleared at once.
module vram_page_and_slot_allocator_core #(
   parameter int MAX_RESERVATIONS  = 64,
   parameter int MAX_PALETTE_PAGES = 8,
   parameter int SLOTS_PER_PAGE    = 8
) (
   input  logic clock,
   input  logic reset,
   vpsa_req_if.sink   req_ch,
   vpsa_rsp_if.source rsp_ch
);
   localparam int NPAGES = vpsa_pkg::NUM_PAGES;
   localparam int PW = $clog2(NPAGES);
   localparam int PCW = $clog2(NPAGES + 1);
   localparam int RW = (MAX_RESERVATIONS > 1) ? $clog2(MAX_RESERVATIONS) : 1;
   localparam int LW = (MAX_PALETTE_PAGES > 1) ? $clog2(MAX_PALETTE_PAGES) : 1;
   localparam int LCW = $clog2(MAX_PALETTE_PAGES + 1);
   localparam int SW = (SLOTS_PER_PAGE > 1) ? $clog2(SLOTS_PER_PAGE) : 1;
   localparam int STRIDE = vpsa_pkg::BLOCKS_PER_PAGE / SLOTS_PER_PAGE;
   localparam int EW = PW + PCW;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_MAP_SCAN, S_TBL_SCAN, S_MARK, S_PAL_SCAN,
      S_FREE_SCAN, S_FREE_RD, S_RUN_SCAN, S_DONE
   } state_type;

   // page map RAM
   logic           map_we;
   logic [PW-1:0]  map_waddr, map_raddr;
   logic           map_wdata, map_rdata;
   // reservation table RAM: page, count
   logic           tbl_we;
   logic [RW-1:0]  tbl_waddr, tbl_raddr;
   logic [EW-1:0]  tbl_wdata, tbl_rdata;

   vpsa_ram #(.WIDTH(1), .DEPTH(NPAGES)) u_map (
      .clock(clock), .wr_en(map_we), .wr_addr(map_waddr), .wr_data(map_wdata),
      .rd_addr(map_raddr), .rd_data(map_rdata));
   vpsa_ram #(.WIDTH(EW), .DEPTH(MAX_RESERVATIONS)) u_tbl (
      .clock(clock), .wr_en(tbl_we), .wr_addr(tbl_waddr), .wr_data(tbl_wdata),
      .rd_addr(tbl_raddr), .rd_data(tbl_rdata));

   state_type                 state_ff;
   vpsa_pkg::req_type         req_ff;
   logic                      pal_mode_ff;   // grant for a new palette page
   logic [PCW:0]              idx_ff;        // scan index, one spare bit
   logic                      rd_pend_ff;    // first read of a scan in flight
   logic [PCW-1:0]            run_ff, best_ff;
   logic [PW-1:0]             start_ff;
   logic [PCW-1:0]            need_ff;
   logic [RW-1:0]             slot_ff;
   logic [MAX_RESERVATIONS-1:0] valid_ff;
   logic [PCW-1:0]            used_ff;
   logic [PW-1:0]             pal_page_ff [MAX_PALETTE_PAGES];
   logic [SLOTS_PER_PAGE-1:0] pal_mask_ff [MAX_PALETTE_PAGES];
   logic [LCW-1:0]            pal_total_ff;
   logic                      rsp_valid_ff;
   vpsa_pkg::rsp_type         rsp_ff;

   assign req_ch.ready   = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_ff;

   // combinational helpers
   logic              map_bit;
   logic [PCW-1:0]    run_next;
   logic [RW-1:0]     free_slot;
   logic              free_found;
   logic [LW-1:0]     pal_idx;
   logic [SW-1:0]     pal_slot;
   logic              pal_found;
   logic [LW-1:0]     fr_idx;
   logic              fr_found;
   logic [SW-1:0]     blk_slot;
   logic              blk_in_range;

   assign map_bit  = map_rdata;
   assign run_next = map_bit ? '0 : run_ff + 1'b1;

   // first invalid reservation entry
   always_comb begin
      free_slot  = '0;
      free_found = 1'b0;
      for (int i = MAX_RESERVATIONS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_slot  = RW'(i);
            free_found = 1'b1;
         end
      end
   end

   // first palette page with a free slot
   always_comb begin
      pal_idx   = '0;
      pal_slot  = '0;
      pal_found = 1'b0;
      for (int p = MAX_PALETTE_PAGES - 1; p >= 0; p--) begin
         if (LCW'(p) < pal_total_ff && !(&pal_mask_ff[p])) begin
            pal_idx   = LW'(p);
            pal_found = 1'b1;
            pal_slot  = '0;
            for (int s = SLOTS_PER_PAGE - 1; s >= 0; s--) begin
               if (!pal_mask_ff[p][s]) begin
                  pal_slot = SW'(s);
               end
            end
         end
      end
   end

   // slot free lookup
   assign blk_in_range = (32'(req_ff.req_block) / STRIDE) < SLOTS_PER_PAGE;
   assign blk_slot     = SW'(32'(req_ff.req_block) / STRIDE);
   always_comb begin
      fr_idx   = '0;
      fr_found = 1'b0;
      for (int p = MAX_PALETTE_PAGES - 1; p >= 0; p--) begin
         if (LCW'(p) < pal_total_ff && pal_page_ff[p] == PW'(req_ff.req_page)) begin
            fr_idx   = LW'(p);
            fr_found = 1'b1;
         end
      end
   end

   // RAM port control
   always_comb begin
      map_we    = 1'b0;
      map_waddr = idx_ff[PW-1:0];
      map_wdata = 1'b0;
      map_raddr = idx_ff[PW-1:0];
      tbl_we    = 1'b0;
      tbl_waddr = slot_ff;
      tbl_wdata = {start_ff, need_ff};
      tbl_raddr = idx_ff[RW-1:0];
      unique case (state_ff)
         S_CLEAR: begin
            map_we = 1'b1;
         end
         S_MARK: begin
            map_we    = 1'b1;
            map_wdata = !(req_ff.operation == vpsa_pkg::OP_FREE);
         end
         S_TBL_SCAN: begin
            tbl_we = 1'b1;
         end
         default: begin
         end
      endcase
   end

   function automatic vpsa_pkg::rsp_type mk_rsp(input vpsa_pkg::status_type st,
         input logic [8:0] pg, input logic [9:0] cnt, input logic [4:0] blk,
         input logic [9:0] lr, input logic [9:0] pf);
      vpsa_pkg::rsp_type r;
      r.ok          = (st == vpsa_pkg::ST_OK);
      r.status      = st;
      r.out_page    = (st == vpsa_pkg::ST_OK) ? pg : '0;
      r.out_count   = (st == vpsa_pkg::ST_OK) ? cnt : '0;
      r.out_block   = (st == vpsa_pkg::ST_OK) ? blk : '0;
      r.pages_free  = pf;
      r.largest_run = lr;
      return r;
   endfunction

   logic [9:0] pf_now;
   assign pf_now = 10'(NPAGES - int'(used_ff));

   // control sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         valid_ff     <= '0;
         used_ff      <= '0;
         pal_total_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
         pal_mode_ff  <= 1'b0;
         for (int p = 0; p < MAX_PALETTE_PAGES; p++) begin
            pal_page_ff[p] <= '0;
            pal_mask_ff[p] <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == (PCW+1)'(NPAGES - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_ch.valid && req_ch.ready) begin
                  req_ff     <= req_ch.payload;
                  idx_ff     <= '0;
                  run_ff     <= '0;
                  best_ff    <= '0;
                  rd_pend_ff <= 1'b1;
                  unique case (vpsa_pkg::op_type'(req_ch.payload.operation))
                     vpsa_pkg::OP_ALLOC_PAGES: begin
                        pal_mode_ff <= 1'b0;
                        need_ff     <= PCW'(req_ch.payload.req_count);
                        if (req_ch.payload.req_count == '0 ||
                            int'(req_ch.payload.req_count) > NPAGES) begin
                           rsp_ff <= mk_rsp(vpsa_pkg::ST_BAD_COUNT, '0, '0, '0, '0, pf_now);
                           state_ff <= S_DONE;
                        end else begin
                           state_ff <= S_MAP_SCAN;
                        end
                     end
                     vpsa_pkg::OP_ALLOC_SLOT: begin
                        state_ff <= S_PAL_SCAN;
                     end
                     vpsa_pkg::OP_FREE: begin
                        state_ff <= S_FREE_SCAN;
                     end
                     vpsa_pkg::OP_QUERY: begin
                        state_ff <= S_RUN_SCAN;
                     end
                     default: begin
                        state_ff <= S_DONE;
                     end
                  endcase
               end
            end
            // first-fit search: one map bit per cycle, map read data is registered
            S_MAP_SCAN: begin
               if (rd_pend_ff) begin
                  rd_pend_ff <= 1'b0;
                  idx_ff     <= idx_ff + 1'b1;
               end else if (run_next == need_ff) begin
                  start_ff <= PW'(idx_ff - 1'b1 + 1'b1 - (PCW+1)'(need_ff));
                  if (!free_found) begin
                     rsp_ff   <= mk_rsp(pal_mode_ff ? vpsa_pkg::ST_TABLE_FULL
                                                    : vpsa_pkg::ST_TABLE_FULL,
                                        '0, '0, '0, '0, pf_now);
                     state_ff <= S_DONE;
                  end else begin
                     slot_ff  <= free_slot;
                     state_ff <= S_TBL_SCAN;
                  end
               end else if (idx_ff == (PCW+1)'(NPAGES)) begin
                  rsp_ff   <= mk_rsp(vpsa_pkg::ST_NO_SPACE, '0, '0, '0, '0, pf_now);
                  state_ff <= S_DONE;
               end else begin
                  run_ff <= run_next;
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            // record the run in the table, then mark the pages
            S_TBL_SCAN: begin
               valid_ff[slot_ff] <= 1'b1;
               idx_ff   <= (PCW+1)'(start_ff);
               run_ff   <= '0;
               state_ff <= S_MARK;
            end
            S_MARK: begin
               idx_ff <= idx_ff + 1'b1;
               run_ff <= run_ff + 1'b1;
               if (run_ff + 1'b1 == need_ff || idx_ff == (PCW+1)'(NPAGES - 1)) begin
                  state_ff <= S_DONE;
                  if (req_ff.operation == vpsa_pkg::OP_FREE) begin
                     used_ff <= (used_ff >= need_ff) ? used_ff - need_ff : '0;
                     rsp_ff  <= mk_rsp(vpsa_pkg::ST_OK, '0, '0, '0, '0,
                                       10'(NPAGES - int'((used_ff >= need_ff) ?
                                           used_ff - need_ff : '0)));
                  end else begin
                     used_ff <= used_ff + need_ff;
                     if (pal_mode_ff) begin
                        pal_page_ff[pal_total_ff[LW-1:0]] <= start_ff;
                        pal_mask_ff[pal_total_ff[LW-1:0]] <= SLOTS_PER_PAGE'(1);
                        pal_total_ff <= pal_total_ff + 1'b1;
                        rsp_ff <= mk_rsp(vpsa_pkg::ST_OK, 9'(start_ff), '0, '0, '0,
                                         10'(NPAGES - int'(used_ff + need_ff)));
                     end else begin
                        rsp_ff <= mk_rsp(vpsa_pkg::ST_OK, 9'(start_ff), 10'(need_ff), '0,
                                         '0, 10'(NPAGES - int'(used_ff + need_ff)));
                     end
                  end
               end
            end
            S_PAL_SCAN: begin
               if (pal_found) begin
                  pal_mask_ff[pal_idx][pal_slot] <= 1'b1;
                  rsp_ff <= mk_rsp(vpsa_pkg::ST_OK, 9'(pal_page_ff[pal_idx]), '0,
                                   5'(int'(pal_slot) * STRIDE), '0, pf_now);
                  state_ff <= S_DONE;
               end else if (int'(pal_total_ff) >= MAX_PALETTE_PAGES) begin
                  rsp_ff   <= mk_rsp(vpsa_pkg::ST_PALETTE_FULL, '0, '0, '0, '0, pf_now);
                  state_ff <= S_DONE;
               end else begin
                  pal_mode_ff <= 1'b1;
                  need_ff     <= PCW'(1);
                  state_ff    <= S_MAP_SCAN;
               end
            end
            // free: slot case is immediate; run case walks the table
            S_FREE_SCAN: begin
               if (req_ff.req_count == '0) begin
                  if (fr_found && blk_in_range) begin
                     pal_mask_ff[fr_idx][blk_slot] <= 1'b0;
                     rsp_ff <= mk_rsp(vpsa_pkg::ST_OK, '0, '0, '0, '0, pf_now);
                  end else begin
                     rsp_ff <= mk_rsp(vpsa_pkg::ST_UNKNOWN_SLOT, '0, '0, '0, '0, pf_now);
                  end
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_FREE_RD;
               end
            end
            S_FREE_RD: begin
               if (rd_pend_ff) begin
                  rd_pend_ff <= 1'b0;
                  idx_ff     <= idx_ff + 1'b1;
               end else if (valid_ff[RW'(idx_ff - 1'b1)] &&
                            tbl_rdata == {PW'(req_ff.req_page), PCW'(req_ff.req_count)}) begin
                  valid_ff[RW'(idx_ff - 1'b1)] <= 1'b0;
                  need_ff  <= PCW'(req_ff.req_count);
                  idx_ff   <= (PCW+1)'(req_ff.req_page);
                  run_ff   <= '0;
                  state_ff <= S_MARK;
               end else if (idx_ff == (PCW+1)'(MAX_RESERVATIONS)) begin
                  rsp_ff   <= mk_rsp(vpsa_pkg::ST_UNKNOWN_RES, '0, '0, '0, '0, pf_now);
                  state_ff <= S_DONE;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            // longest free run over the whole map
            S_RUN_SCAN: begin
               if (rd_pend_ff) begin
                  rd_pend_ff <= 1'b0;
                  idx_ff     <= idx_ff + 1'b1;
               end else begin
                  run_ff <= run_next;
                  if (run_next > best_ff) begin
                     best_ff <= run_next;
                  end
                  if (idx_ff == (PCW+1)'(NPAGES)) begin
                     rsp_ff <= mk_rsp(vpsa_pkg::ST_OK, '0, '0, '0,
                                      10'((run_next > best_ff) ? run_next : best_ff), pf_now);
                     state_ff <= S_DONE;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end
            end
            S_DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      int'(used_ff) <= NPAGES) else $error("used page total over range");
   a_pal_bound: assert property (@(posedge clock) disable iff (reset)
      int'(pal_total_ff) <= MAX_PALETTE_PAGES) else $error("palette total over range");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !rsp_valid_ff) else $error("accept with pending result");
   a_ok_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.ok == (rsp_ff.status == vpsa_pkg::ST_OK)))
      else $error("ok and status disagree");
`endif
endmodule

// ----- verif/tb_vram_page_and_slot_allocator_core.sv -----
`timescale 1ns / 100ps

module tb_vram_page_and_slot_allocator_core;

   localparam int PAGES      = vpsa_pkg::NUM_PAGES;
   localparam int RES_DEPTH  = 64;
   localparam int PAL_PAGES  = 8;
   localparam int SLOTS      = 8;
   localparam int STRIDE     = vpsa_pkg::BLOCKS_PER_PAGE / SLOTS;
   localparam int N_RANDOM   = 1930;
   localparam int DRAIN_WAIT = 2 * PAGES + RES_DEPTH + 64;
   localparam longint CYCLE_LIMIT = 12_000_000;

   logic clock;
   logic reset;

   vpsa_req_if req_ch ();
   vpsa_rsp_if rsp_ch ();

   vram_page_and_slot_allocator_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   // allocator shadow state
   bit          map_used [PAGES];
   bit          res_valid [RES_DEPTH];
   int unsigned res_page [RES_DEPTH];
   int unsigned res_count [RES_DEPTH];
   int unsigned used_total;
   int unsigned pal_page [PAL_PAGES];
   bit [7:0]    pal_mask [PAL_PAGES];
   int unsigned pal_total;

   vpsa_pkg::rsp_type pending_rsp [$];
   int          errors;
   longint      cycles;
   int          hold_cycles;

   // directed stimulus row
   typedef struct {
      vpsa_pkg::op_type  op;
      int unsigned       page;
      int unsigned       count;
      int unsigned       block;
      bit                typed;
      vpsa_pkg::rsp_type exp;
   } vector_row;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // first-fit run grant into the first free table entry
   function automatic vpsa_pkg::status_type grant_run(input int unsigned cnt,
                                                      output int unsigned start);
      int unsigned run;
      int          found;
      int          entry;
      start = 0;
      found = -1;
      entry = -1;
      run   = 0;
      if (cnt == 0 || cnt > PAGES) return vpsa_pkg::ST_BAD_COUNT;
      for (int i = 0; i < PAGES; i++) begin
         run = map_used[i] ? 0 : run + 1;
         if (run == cnt) begin
            found = i + 1 - cnt;
            break;
         end
      end
      if (found < 0) return vpsa_pkg::ST_NO_SPACE;
      for (int i = 0; i < RES_DEPTH; i++) begin
         if (!res_valid[i]) begin
            entry = i;
            break;
         end
      end
      if (entry < 0) return vpsa_pkg::ST_TABLE_FULL;
      for (int i = 0; i < cnt; i++) map_used[found + i] = 1'b1;
      used_total += cnt;
      res_valid[entry] = 1'b1;
      res_page[entry]  = found;
      res_count[entry] = cnt;
      start = found;
      return vpsa_pkg::ST_OK;
   endfunction

   // work out the result of one request and update the shadow state
   function automatic vpsa_pkg::rsp_type allocate_result(input vpsa_pkg::req_type r);
      vpsa_pkg::rsp_type    o;
      vpsa_pkg::status_type st;
      int unsigned pg;
      int unsigned opage;
      int unsigned ocount;
      int unsigned oblock;
      int unsigned lrun;
      int unsigned run;
      int unsigned idx;
      bit          done;
      st = vpsa_pkg::ST_OK;
      opage = 0; ocount = 0; oblock = 0; lrun = 0; done = 0;
      case (vpsa_pkg::op_type'(r.operation))
         vpsa_pkg::OP_ALLOC_PAGES: begin
            st = grant_run(r.req_count, pg);
            if (st == vpsa_pkg::ST_OK) begin
               opage  = pg;
               ocount = r.req_count;
            end
         end
         vpsa_pkg::OP_ALLOC_SLOT: begin
            for (int p = 0; p < pal_total && !done; p++) begin
               for (int s = 0; s < SLOTS; s++) begin
                  if (!pal_mask[p][s]) begin
                     pal_mask[p][s] = 1'b1;
                     opage  = pal_page[p];
                     oblock = s * STRIDE;
                     done   = 1;
                     break;
                  end
               end
            end
            if (!done) begin
               if (pal_total >= PAL_PAGES) st = vpsa_pkg::ST_PALETTE_FULL;
               else begin
                  st = grant_run(1, pg);
                  if (st == vpsa_pkg::ST_OK) begin
                     pal_page[pal_total] = pg;
                     pal_mask[pal_total] = 8'h01;
                     pal_total++;
                     opage = pg;
                  end
               end
            end
         end
         vpsa_pkg::OP_FREE: begin
            if (r.req_count == 0) begin
               idx = r.req_block / STRIDE;
               st  = vpsa_pkg::ST_UNKNOWN_SLOT;
               for (int p = 0; p < pal_total; p++) begin
                  if (pal_page[p] == r.req_page && idx < SLOTS) begin
                     pal_mask[p][idx] = 1'b0;
                     st = vpsa_pkg::ST_OK;
                     break;
                  end
               end
            end else begin
               st = vpsa_pkg::ST_UNKNOWN_RES;
               for (int p = 0; p < RES_DEPTH; p++) begin
                  if (res_valid[p] && res_page[p] == r.req_page
                      && res_count[p] == r.req_count) begin
                     for (int i = 0; i < res_count[p]; i++) map_used[res_page[p] + i] = 1'b0;
                     used_total = (used_total >= res_count[p]) ? used_total - res_count[p] : 0;
                     res_valid[p] = 1'b0;
                     res_page[p]  = 0;
                     res_count[p] = 0;
                     st = vpsa_pkg::ST_OK;
                     break;
                  end
               end
            end
         end
         default: begin
            run = 0;
            for (int i = 0; i < PAGES; i++) begin
               run = map_used[i] ? 0 : run + 1;
               if (run > lrun) lrun = run;
            end
         end
      endcase
      if (st != vpsa_pkg::ST_OK) begin
         opage = 0; ocount = 0; oblock = 0;
      end
      o.ok          = (st == vpsa_pkg::ST_OK);
      o.status      = st;
      o.out_page    = opage[8:0];
      o.out_count   = ocount[9:0];
      o.out_block   = oblock[4:0];
      o.pages_free  = (used_total <= PAGES) ? 10'(PAGES - used_total) : 10'd0;
      o.largest_run = lrun[9:0];
      return o;
   endfunction

   function automatic int unsigned gap_length();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(3, 1);
      return $urandom_range(80, 10);
   endfunction

   function automatic vpsa_pkg::rsp_type mk_rsp(input vpsa_pkg::status_type st,
                                      input int unsigned page,
                                      input int unsigned count, input int unsigned block,
                                      input int unsigned pfree, input int unsigned lrun);
      vpsa_pkg::rsp_type o;
      o.ok          = (st == vpsa_pkg::ST_OK);
      o.status      = st;
      o.out_page    = page[8:0];
      o.out_count   = count[9:0];
      o.out_block   = block[4:0];
      o.pages_free  = pfree[9:0];
      o.largest_run = lrun[9:0];
      return o;
   endfunction

   // random request, mostly well-formed against the current shadow state
   function automatic vpsa_pkg::req_type random_request(input int item);
      vpsa_pkg::req_type r;
      int unsigned roll;
      int          live [$];
      int          pick;
      bit          fill_phase;
      r.operation = vpsa_pkg::OP_QUERY;
      r.req_page  = 9'($urandom);
      r.req_count = 10'($urandom);
      r.req_block = 5'($urandom);
      fill_phase = ((item / 250) % 2) == 0;
      roll = $urandom_range(99);
      if (roll < (fill_phase ? 40 : 20)) begin
         r.operation = vpsa_pkg::OP_ALLOC_PAGES;
         roll = $urandom_range(99);
         if (roll < 4) r.req_count = ($urandom_range(1) == 0) ? 10'd0
                                                              : 10'($urandom_range(1023, 513));
         else if (roll < 8) r.req_count = 10'($urandom_range(512, 100));
         else r.req_count = 10'($urandom_range(16, 1));
      end else if (roll < (fill_phase ? 62 : 42)) begin
         r.operation = vpsa_pkg::OP_ALLOC_SLOT;
      end else if (roll < 85) begin
         r.operation = vpsa_pkg::OP_FREE;
         for (int i = 0; i < RES_DEPTH; i++) if (res_valid[i]) live.push_back(i);
         if ($urandom_range(99) < 30 && pal_total > 0) begin
            r.req_count = 0;
            r.req_page  = 9'(pal_page[$urandom_range(pal_total - 1)]);
         end else if ($urandom_range(99) < 85 && live.size() > 0) begin
            pick = live[$urandom_range(live.size() - 1)];
            r.req_page  = 9'(res_page[pick]);
            r.req_count = 10'(res_count[pick]);
         end else if ($urandom_range(1) == 0) begin
            r.req_count = 0;
         end
      end else begin
         r.operation = vpsa_pkg::OP_QUERY;
      end
      return r;
   endfunction

   task automatic send_request(input vpsa_pkg::req_type r, input vpsa_pkg::rsp_type exp,
                               input bit typed);
      vpsa_pkg::rsp_type calc;
      req_ch.valid   <= 1'b1;
      req_ch.payload <= r;
      do @(posedge clock); while (!req_ch.ready);
      calc = allocate_result(r);
      pending_rsp.push_back(typed ? exp : calc);
      @(negedge clock);
   endtask

   // sender
   initial begin
      vector_row         vec [$];
      vpsa_pkg::req_type r;
      int unsigned       gap;
      vpsa_pkg::rsp_type none;
      none = '0;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      errors = 0;
      hold_cycles = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      vec = '{
         '{vpsa_pkg::OP_QUERY, 0, 0, 0, 1, mk_rsp(vpsa_pkg::ST_OK, 0, 0, 0, 512, 512)},
         '{vpsa_pkg::OP_ALLOC_PAGES, 0, 0, 0, 1,
           mk_rsp(vpsa_pkg::ST_BAD_COUNT, 0, 0, 0, 512, 0)},
         '{vpsa_pkg::OP_ALLOC_PAGES, 0, 513, 0, 1,
           mk_rsp(vpsa_pkg::ST_BAD_COUNT, 0, 0, 0, 512, 0)},
         '{vpsa_pkg::OP_ALLOC_PAGES, 511, 1023, 31, 1,
           mk_rsp(vpsa_pkg::ST_BAD_COUNT, 0, 0, 0, 512, 0)},
         '{vpsa_pkg::OP_ALLOC_PAGES, 0, 512, 0, 1, mk_rsp(vpsa_pkg::ST_OK, 0, 512, 0, 0, 0)},
         '{vpsa_pkg::OP_ALLOC_PAGES, 0, 1, 0, 1, mk_rsp(vpsa_pkg::ST_NO_SPACE, 0, 0, 0, 0, 0)},
         '{vpsa_pkg::OP_QUERY, 0, 0, 0, 1, mk_rsp(vpsa_pkg::ST_OK, 0, 0, 0, 0, 0)},
         '{vpsa_pkg::OP_ALLOC_SLOT, 0, 0, 0, 1, mk_rsp(vpsa_pkg::ST_NO_SPACE, 0, 0, 0, 0, 0)},
         '{vpsa_pkg::OP_FREE, 0, 511, 0, 1, mk_rsp(vpsa_pkg::ST_UNKNOWN_RES, 0, 0, 0, 0, 0)},
         '{vpsa_pkg::OP_FREE, 0, 512, 0, 1, mk_rsp(vpsa_pkg::ST_OK, 0, 0, 0, 512, 0)},
         '{vpsa_pkg::OP_ALLOC_SLOT, 0, 0, 0, 1, mk_rsp(vpsa_pkg::ST_OK, 0, 0, 0, 511, 0)},
         '{vpsa_pkg::OP_ALLOC_SLOT, 0, 0, 0, 1, mk_rsp(vpsa_pkg::ST_OK, 0, 0, 4, 511, 0)},
         '{vpsa_pkg::OP_FREE, 0, 0, 31, 1, mk_rsp(vpsa_pkg::ST_OK, 0, 0, 0, 511, 0)},
         '{vpsa_pkg::OP_FREE, 5, 0, 0, 1,
           mk_rsp(vpsa_pkg::ST_UNKNOWN_SLOT, 0, 0, 0, 511, 0)},
         '{vpsa_pkg::OP_FREE,        0,    0,  5, 0, none},
         '{vpsa_pkg::OP_ALLOC_SLOT,  0,    0,  0, 0, none},
         '{vpsa_pkg::OP_ALLOC_PAGES, 0,    3,  0, 0, none},
         '{vpsa_pkg::OP_FREE,      511,    1, 17, 0, none},
         '{vpsa_pkg::OP_FREE,        0,    1,  0, 0, none},
         '{vpsa_pkg::OP_ALLOC_SLOT,  0,    0,  0, 0, none},
         '{vpsa_pkg::OP_ALLOC_PAGES, 0,  509,  0, 0, none},
         '{vpsa_pkg::OP_QUERY,     511, 1023, 31, 0, none}
      };

      foreach (vec[i]) begin
         r.operation = vec[i].op;
         r.req_page  = 9'(vec[i].page);
         r.req_count = 10'(vec[i].count);
         r.req_block = 5'(vec[i].block);
         send_request(r, vec[i].exp, vec[i].typed);
      end

      for (int n = 0; n < N_RANDOM; n++) begin
         // long receiver hold-off while requests keep coming
         if (n == 300) hold_cycles = 6000;
         // sender waits for every outstanding result
         if (n == 900) begin
            req_ch.valid <= 1'b0;
            wait (pending_rsp.size() == 0);
            @(negedge clock);
         end
         gap = (n >= 300 && n < 320) ? 0 : gap_length();
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         send_request(random_request(n), none, 0);
      end
      req_ch.valid <= 1'b0;

      wait (pending_rsp.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   // receiver back-pressure
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ch.ready <= 1'b0;
         end else if ((cycles / 3000) % 4 == 1) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) < 70);
         end
      end
   end

   // result check against the oldest expectation
   always @(posedge clock) begin
      vpsa_pkg::rsp_type got;
      vpsa_pkg::rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.payload;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected transaction, actual %h", $time, got);
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            if (got.ok !== want.ok) begin
               $display("%0t: ok expected %0d actual %0d", $time, want.ok, got.ok);
               errors++;
            end
            if (got.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
               errors++;
            end
            if (got.out_page !== want.out_page) begin
               $display("%0t: out_page expected %0d actual %0d",
                        $time, want.out_page, got.out_page);
               errors++;
            end
            if (got.out_count !== want.out_count) begin
               $display("%0t: out_count expected %0d actual %0d",
                        $time, want.out_count, got.out_count);
               errors++;
            end
            if (got.out_block !== want.out_block) begin
               $display("%0t: out_block expected %0d actual %0d",
                        $time, want.out_block, got.out_block);
               errors++;
            end
            if (got.pages_free !== want.pages_free) begin
               $display("%0t: pages_free expected %0d actual %0d",
                        $time, want.pages_free, got.pages_free);
               errors++;
            end
            if (got.largest_run !== want.largest_run) begin
               $display("%0t: largest_run expected %0d actual %0d",
                        $time, want.largest_run, got.largest_run);
               errors++;
            end
         end
      end
   end

   // watchdog
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

endmodule
